// File: sv/skts_pkg.sv
package skts_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int INDEX_W     = 10;
	localparam int KEY_VALUE_W = 64;
	localparam int COUNT_W     = 11;
	localparam int POSITION_W  = 10;
	localparam int S_TDATA_W   = 80;
	localparam int M_TDATA_W   = 16;

	// Defaults for the top-level parameters.
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int KEY_BYTES_DEF   = 8;

	// Entries of the command queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Function codes carried in the slave-side tuser.
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

endpackage

// File: sv/sorted_key_table_search.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid / s_axis_tready tuser: func; tdata: entry_index, key_value
// m_axis    out        m_axis_tvalid / m_axis_tready tuser: found; tdata: position
// cfg       in         cfg_valid / cfg_ready         cfg_data: key_count
//
// A load transaction writes the key RAM in the back end as it is popped from the queue.
// A search starts in the back end, probes (unless key_count is zero) through the single
// registered read port of the key RAM, makes one equality check when the lower bound
// lies below key_count, and then hands the result to the output register.
// Reset clears the control state and key_count; the key table is not cleared.
// A stalled output holds one result while the front keeps filling the command queue.
module sorted_key_table_search #(
	parameter int TABLE_DEPTH = skts_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BYTES   = skts_pkg::KEY_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [9:0] entry_index, [73:10] key_value, [79:74] zero
	input  logic [skts_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] func
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [9:0] position, [15:10] zero
	output logic [skts_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [0] found
	output logic                           m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [skts_pkg::COUNT_W-1:0]   cfg_data
);
	import skts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int KW = 8 * KEY_BYTES;
	localparam int QW = 1 + AW + KW;

	logic          q_push;
	logic [QW-1:0] q_wdata;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [QW-1:0] q_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [KW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [KW-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	skts_front #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BYTES  (KEY_BYTES)
	) u_front (
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_data       (q_wdata)
	);

	skts_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.valid (q_valid),
		.rdata (q_rdata)
	);

	skts_back #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BYTES  (KEY_BYTES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.q_data       (q_rdata),
		.q_pop        (q_pop),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	skts_ram #(
		.WIDTH(KW),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("command popped from an empty queue");

	a_write_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> q_pop)
		else $error("key RAM written without a popped load command");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_valid)
		else $error("input stalled while the command queue is empty");

	a_miss_position_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("miss result carries a nonzero position");

endmodule

// File: sv/skts_ram.sv
module skts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/skts_fifo.sv
module skts_fifo #(
	parameter int WIDTH = 75,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNTW-1:0]  fill_q;

	assign full  = (fill_q == CNTW'(DEPTH));
	assign valid = (fill_q != '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: sv/skts_front.sv
module skts_front #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES   = 8
) (
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [skts_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	input  logic                                s_axis_tuser,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [$clog2(TABLE_DEPTH)+8*KEY_BYTES:0] q_data
);
	import skts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int KW = 8 * KEY_BYTES;

	logic [INDEX_W-1:0]     entry_index;
	logic [KEY_VALUE_W-1:0] key_value;
	logic [INDEX_W+15:0]    index_ext;
	logic [31:0]            index_wide;
	logic                   in_range;
	logic                   keep;

	assign entry_index = s_axis_tdata[INDEX_W-1:0];
	assign key_value   = s_axis_tdata[INDEX_W +: KEY_VALUE_W];
	assign index_ext   = {16'b0, entry_index};
	assign index_wide  = 32'(entry_index);

	// Loads beyond the table are accepted and dropped here.
	assign in_range = (index_wide < 32'(TABLE_DEPTH));
	assign keep     = (s_axis_tuser == FUNC_SEARCH) || in_range;

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full && keep;
	assign q_data        = {s_axis_tuser, index_ext[AW-1:0], key_value[KW-1:0]};

endmodule

// File: sv/skts_back.sv
module skts_back #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BYTES   = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	input  logic [skts_pkg::COUNT_W-1:0]             cfg_data,
	input  logic                                     q_valid,
	input  logic [$clog2(TABLE_DEPTH)+8*KEY_BYTES:0] q_data,
	output logic                                     q_pop,
	output logic                                     ram_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]           ram_waddr,
	output logic [8*KEY_BYTES-1:0]                   ram_wdata,
	output logic [$clog2(TABLE_DEPTH)-1:0]           ram_raddr,
	input  logic [8*KEY_BYTES-1:0]                   ram_rdata,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [skts_pkg::M_TDATA_W-1:0]           m_axis_tdata,
	output logic                                     m_axis_tuser
);
	import skts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int KW = 8 * KEY_BYTES;
	localparam int CW = AW + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         lo_q;
	logic [CW-1:0]         hi_q;
	logic [CW-1:0]         mid_q;
	logic [KW-1:0]         key_q;
	logic                  res_found_q;
	logic [POSITION_W-1:0] res_pos_q;
	logic                  m_valid_q;
	logic                  m_found_q;
	logic [POSITION_W-1:0] m_pos_q;

	logic                     q_func;
	logic [AW-1:0]            q_addr;
	logic [KW-1:0]            q_key;
	logic                     start_search;
	logic                     out_free;
	logic                     less;
	logic [CW-1:0]            lo_n;
	logic [CW-1:0]            hi_n;
	logic [CW:0]              sum_n;
	logic [CW-1:0]            mid_n;
	logic [CW-1:0]            mid_first;
	logic [CW+POSITION_W-1:0] lo_ext;
	logic [POSITION_W-1:0]    lo_pos;

	assign q_func = q_data[KW+AW];
	assign q_addr = q_data[KW +: AW];
	assign q_key  = q_data[KW-1:0];

	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign start_search = q_pop && (q_func == FUNC_SEARCH);
	assign ram_we       = q_pop && (q_func == FUNC_LOAD);
	assign ram_waddr    = q_addr;
	assign ram_wdata    = q_key;

	assign out_free = !m_valid_q || m_axis_tready;

	// One probe per cycle: the registered read of mid arrives, the bounds
	// narrow, and the next midpoint goes straight back to the read port.
	assign less      = (ram_rdata < key_q);
	assign lo_n      = less ? mid_q + 1'b1 : lo_q;
	assign hi_n      = less ? hi_q : mid_q;
	assign sum_n     = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n     = sum_n[CW:1];
	assign mid_first = count_q >> 1;

	assign lo_ext = {{POSITION_W{1'b0}}, lo_q};
	assign lo_pos = lo_ext[POSITION_W-1:0];

	always_comb begin
		unique case (state_q)
			ST_IDLE:  ram_raddr = mid_first[AW-1:0];
			ST_PROBE: ram_raddr = (lo_n < hi_n) ? mid_n[AW-1:0] : lo_n[AW-1:0];
			default:  ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (int'(cfg_data) > TABLE_DEPTH) begin
					count_q <= CW'(TABLE_DEPTH);
				end else begin
					count_q <= CW'(cfg_data);
				end
			end
			if ((state_q == ST_DONE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_search) begin
						state_q <= (count_q != '0) ? ST_PROBE : ST_DONE;
					end
				end
				ST_PROBE: begin
					if (lo_n < hi_n) begin
						state_q <= ST_PROBE;
					end else if (lo_n < count_q) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CHECK: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start_search) begin
					key_q       <= q_key;
					lo_q        <= '0;
					hi_q        <= count_q;
					mid_q       <= mid_first;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			ST_PROBE: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			ST_CHECK: begin
				if (ram_rdata == key_q) begin
					res_found_q <= 1'b1;
					res_pos_q   <= lo_pos;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_found_q <= res_found_q;
					m_pos_q   <= res_pos_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_found_q;
	assign m_axis_tdata  = {{(M_TDATA_W - POSITION_W){1'b0}}, m_pos_q};

endmodule

// File: tb/sv/tb_sorted_key_table_search.sv
`timescale 1ns / 100ps

module tb_sorted_key_table_search;
	import skts_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam int KEY_BYTES   = KEY_BYTES_DEF;
	localparam logic [KEY_VALUE_W-1:0] KEY_MASK =
		{KEY_VALUE_W{1'b1}} >> (KEY_VALUE_W - 8 * KEY_BYTES);
	localparam logic [KEY_VALUE_W-1:0] KEY_ONES = {KEY_VALUE_W{1'b1}};
	localparam int SETTLE_CYCLES    = 32;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int MAX_REPORTS      = 10;
	localparam int PHASE_ITEMS      = 20;
	localparam int SWAP_IDLE_AT     = 460;
	localparam int NO_IDLE_AT       = 920;

	typedef struct packed {
		logic                  found;
		logic [POSITION_W-1:0] position;
	} lookup_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_SEARCH} row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [INDEX_W-1:0]     slot;
		logic [KEY_VALUE_W-1:0] key;	// key_count value on a ROW_CFG row
		bit                     typed;
		lookup_t                answer;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// [9:0] entry_index, [73:10] key_value, [79:74] zero
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// [0] func
	logic                 s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// [9:0] position, [15:10] zero
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// [0] found
	logic                 m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [COUNT_W-1:0]   cfg_data;

	logic [KEY_VALUE_W-1:0] key_shadow [TABLE_DEPTH];
	logic [COUNT_W-1:0]     shadow_count;
	lookup_t                pending_results [$];
	stim_row_t              directed_rows [$];

	int send_idle_pct   = 15;
	int recv_idle_pct   = 71;
	int hold_requests   = 0;
	int holds_served    = 0;
	int hold_left       = 0;
	int error_count     = 0;
	int cycle_count     = 0;
	int items_sent      = 0;
	int loads_sent      = 0;
	int searches_sent   = 0;
	int results_checked = 0;
	int cfg_writes      = 0;

	sorted_key_table_search uut (
		.clk,
		.arst_n,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tuser,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tuser,
		.cfg_valid,
		.cfg_ready,
		.cfg_data
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Lower-bound search over the mirrored table, then an equality test on that slot.
	function automatic lookup_t predict_lookup(input logic [KEY_VALUE_W-1:0] raw_key);
		logic [KEY_VALUE_W-1:0] key;
		int span;
		int lo;
		int hi;
		int mid;
		lookup_t res;
		key = raw_key & KEY_MASK;
		span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
		lo = 0;
		hi = span;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if ((key_shadow[mid] & KEY_MASK) < key)
				lo = mid + 1;
			else
				hi = mid;
		end
		res.found = 1'b0;
		res.position = '0;
		if (lo < span && (key_shadow[lo] & KEY_MASK) == key) begin
			res.found = 1'b1;
			res.position = POSITION_W'(lo);
		end
		return res;
	endfunction

	// Half of the keys sit in the live part of the table; the rest are near misses, random keys and extremes.
	function automatic logic [KEY_VALUE_W-1:0] pick_search_key();
		int span;
		logic [KEY_VALUE_W-1:0] k;
		span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
		k = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: if (span > 0) k = key_shadow[$urandom_range(0, span - 1)];
			5: if (span > 0) k = key_shadow[$urandom_range(0, span - 1)] + 1'b1;
			6: if (span > 0) k = key_shadow[$urandom_range(0, span - 1)] - 1'b1;
			7: ;
			8: k = '0;
			default: k = KEY_ONES;
		endcase
		return k;
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic [INDEX_W-1:0] slot,
			input logic [KEY_VALUE_W-1:0] key, input bit typed, input logic found,
			input logic [POSITION_W-1:0] position);
		stim_row_t row;
		row.kind = kind;
		row.slot = slot;
		row.key = key;
		row.typed = typed;
		row.answer.found = found;
		row.answer.position = position;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t ns: mismatch: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result found=%0b position=%0d with no search pending",
					m_axis_tuser, m_axis_tdata[POSITION_W-1:0]));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (m_axis_tuser !== want.found)
					report_mismatch($sformatf("found expected %0b, got %0b",
						want.found, m_axis_tuser));
				if (m_axis_tdata[POSITION_W-1:0] !== want.position)
					report_mismatch($sformatf("position expected %0d, got %0d",
						want.position, m_axis_tdata[POSITION_W-1:0]));
			end
		end
	end

	// Result side: random back-pressure, or a long hold when the stimulus asks for one.
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic offer_item(input logic func, input logic [INDEX_W-1:0] slot,
			input logic [KEY_VALUE_W-1:0] key, input bit typed, input lookup_t answer);
		lookup_t expected;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {{(S_TDATA_W - KEY_VALUE_W - INDEX_W){1'b0}}, key, slot};
		do @(posedge clk); while (!s_axis_tready);
		if (func == FUNC_LOAD) begin
			key_shadow[slot] = key & KEY_MASK;
			loads_sent++;
		end else begin
			expected = typed ? answer : predict_lookup(key);
			pending_results.insert(pending_results.size(), expected);
			searches_sent++;
		end
		items_sent++;
		if (items_sent == SWAP_IDLE_AT) begin
			send_idle_pct = 71;
			recv_idle_pct = 15;
		end else if (items_sent == NO_IDLE_AT) begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Loads leave no result behind, so give the back end time to retire them first.
	task automatic write_key_count(input logic [COUNT_W-1:0] value);
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_count = value;
		cfg_writes++;
	endtask

	initial begin
		logic [KEY_VALUE_W:0]   next_key;
		logic [KEY_VALUE_W-1:0] step;
		logic [KEY_VALUE_W-1:0] key;
		int slot;
		int phase_counts [10];
		lookup_t no_answer;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_LOAD;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		shadow_count  = '0;
		no_answer     = '0;

		// Empty table, then a five-entry table spanning both extremes and the top bit.
		add_row(ROW_CFG,    0,    64'd0,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'd0,                 1, 0, 0);
		add_row(ROW_SEARCH, 1023, KEY_ONES,              1, 0, 0);
		add_row(ROW_LOAD,   0,    64'd0,                 0, 0, 0);
		add_row(ROW_LOAD,   1,    64'd5,                 0, 0, 0);
		add_row(ROW_LOAD,   2,    64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
		add_row(ROW_LOAD,   3,    64'h8000_0000_0000_0000, 0, 0, 0);
		add_row(ROW_LOAD,   4,    KEY_ONES,              0, 0, 0);
		add_row(ROW_LOAD,   1023, 64'h1234,              0, 0, 0);
		add_row(ROW_CFG,    0,    64'd5,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'd0,                 1, 1, 0);
		add_row(ROW_SEARCH, 512,  KEY_ONES,              1, 1, 4);
		add_row(ROW_SEARCH, 3,    64'h8000_0000_0000_0000, 1, 1, 3);
		add_row(ROW_SEARCH, 2,    64'h7FFF_FFFF_FFFF_FFFF, 1, 1, 2);
		add_row(ROW_SEARCH, 1,    64'd3,                 1, 0, 0);
		add_row(ROW_SEARCH, 4,    64'hFFFF_FFFF_FFFF_FFFE, 1, 0, 0);
		add_row(ROW_CFG,    0,    64'd1,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'd0,                 1, 1, 0);
		add_row(ROW_SEARCH, 0,    64'd5,                 1, 0, 0);
		add_row(ROW_CFG,    0,    64'd5,                 0, 0, 0);
		// Slot 2 now breaks the ordering; the probe path still decides the answer.
		add_row(ROW_LOAD,   2,    64'd1,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'd1,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'd5,                 0, 0, 0);
		add_row(ROW_SEARCH, 0,    64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0);
		add_row(ROW_SEARCH, 0,    KEY_ONES,              0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_CFG: write_key_count(COUNT_W'(directed_rows[i].key));
				ROW_LOAD: offer_item(FUNC_LOAD, directed_rows[i].slot, directed_rows[i].key,
					1'b0, no_answer);
				default: offer_item(FUNC_SEARCH, directed_rows[i].slot, directed_rows[i].key,
					directed_rows[i].typed, directed_rows[i].answer);
			endcase
		end

		// Fill every slot with an ascending key sequence (with duplicates), searching the
		// five live entries in between.
		next_key = '0;
		for (slot = 0; slot < TABLE_DEPTH; slot++) begin
			while ($urandom_range(0, 99) < 12)
				offer_item(FUNC_SEARCH, INDEX_W'($urandom), pick_search_key(), 1'b0, no_answer);
			if (slot == TABLE_DEPTH / 2)
				wait_results_drained();
			offer_item(FUNC_LOAD, INDEX_W'(slot), next_key[KEY_VALUE_W-1:0], 1'b0, no_answer);
			step = ($urandom_range(0, 7) == 0) ? '0 : ({$urandom, $urandom} >> 9);
			next_key = next_key + step;
			if (next_key[KEY_VALUE_W])
				next_key = {1'b0, KEY_ONES};
		end

		phase_counts = '{1024, 2047, 1, 2, 1023, 1025, 512, 0, 0, 3};
		phase_counts[7] = $urandom_range(0, 2047);
		foreach (phase_counts[p]) begin
			write_key_count(COUNT_W'(phase_counts[p]));
			if (phase_counts[p] == TABLE_DEPTH)
				hold_requests++;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0) begin
					// Copying a neighbor keeps the table sorted; a random key does not.
					slot = $urandom_range(0, TABLE_DEPTH - 1);
					case ($urandom_range(0, 3))
						0: key = {$urandom, $urandom};
						1: key = (slot > 0) ? key_shadow[slot - 1] : '0;
						default: key = (slot < TABLE_DEPTH - 1) ? key_shadow[slot + 1] : KEY_ONES;
					endcase
					offer_item(FUNC_LOAD, INDEX_W'(slot), key, 1'b0, no_answer);
				end else begin
					offer_item(FUNC_SEARCH, INDEX_W'($urandom), pick_search_key(), 1'b0,
						no_answer);
				end
			end
		end

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d loads and %0d searches, %0d results compared, %0d key_count writes.",
			loads_sent, searches_sent, results_checked, cfg_writes);
		$display("Empty, partial, full and oversized tables were searched under three idle mixes.");
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: filelist.f
sv/skts_pkg.sv
sv/skts_ram.sv
sv/skts_fifo.sv
sv/skts_front.sv
sv/skts_back.sv
sv/sorted_key_table_search.sv
tb/sv/tb_sorted_key_table_search.sv
